@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PNGSU_ASSERT_IMPL(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define PNGSU_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pngsu_pkg.sv @@
// Package for the PNG scanline unfilter: filter codes, register map, Paeth predictor.
// No dependencies.
`timescale 1ns / 1ps

package pngsu_pkg;

   // filter type codes carried in the row-start byte
   localparam logic [7:0] FILTER_NONE  = 8'd0;
   localparam logic [7:0] FILTER_SUB   = 8'd1;
   localparam logic [7:0] FILTER_UP    = 8'd2;
   localparam logic [7:0] FILTER_AVG   = 8'd3;
   localparam logic [7:0] FILTER_PAETH = 8'd4;

   // register map, word index = paddr[2]
   localparam logic REG_BYTES_PER_PIXEL = 1'b0;

   localparam int POS_W = 14;
   localparam int IDX_W = 13;
   localparam logic [POS_W-1:0] POS_SAT = '1;
   localparam logic [IDX_W-1:0] IDX_SAT = '1;
   localparam logic [3:0] BPP_RESET = 4'd1;
   localparam logic [3:0] BPP_MAX   = 4'd8;

   // Paeth predictor; p - a = b - c, p - b = a - c, p - c = (a - c) + (b - c)
   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] dac;
      logic signed [9:0] dbc;
      logic signed [9:0] dp;
      logic [8:0] pa;
      logic [8:0] pb;
      logic [8:0] pc;
      dac = $signed({2'b00, a}) - $signed({2'b00, c});
      dbc = $signed({2'b00, b}) - $signed({2'b00, c});
      dp  = dac + dbc;
      pa  = dbc[9] ? 9'(-dbc) : 9'(dbc);
      pb  = dac[9] ? 9'(-dac) : 9'(dac);
      pc  = dp[9]  ? 9'(-dp)  : 9'(dp);
      if (pa <= pb && pa <= pc) begin
         paeth = a;
      end else if (pb <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   endfunction

endpackage

@@ rtl/core/png_scanline_unfilter_unit.sv @@
// PNG scanline unfilter: rebuilds raw bytes from filtered scanline bytes.
// Depends on pngsu_pkg; checked by pngsu_checker (bound in its own file).
//
//   channel | role   | ports            | contents
//   req     | in     | req_t*           | tdata: data_byte; tuser: starts_row, first_row
//   rsp     | out    | rsp_t*           | tdata: pixel_byte, byte_index; tuser: overflow
//   csr     | config | csr_p*           | bytes_per_pixel at byte address 0
//
// One byte per cycle sustained while results are taken: each in-range data byte issues
// one line-memory read at acceptance, which the compute stage consumes.
// A result passes through the compute stage register and then the output register,
// where it becomes valid.
// Reset (synchronous) empties the pipeline and clears neighbors and row state;
// the line memory is not cleared and is written as rows arrive.
// A stalled result holds in the output register; the compute stage holds behind
// it and requests stop being taken only when both are full.
`timescale 1ns / 1ps

module png_scanline_unfilter_unit #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [1:0]  req_tuser,    // [0] starts_row, [1] first_row
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] pixel_byte, [20:8] byte_index, [23:21] zero
   output logic        rsp_tuser,    // [0] overflow
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int PW = pngsu_pkg::POS_W;
   localparam int IW = pngsu_pkg::IDX_W;

   // register
   logic [3:0] bpp_ff, bpp_in;

   // fetch side
   logic [PW-1:0] pos_ff, pos_in;
   logic          req_accept;
   logic          req_start;
   logic          req_in_range;

   // line memory
   logic [7:0]    line_mem [MAX_ROW_BYTES];
   logic [7:0]    mem_rdata_ff;
   logic          mem_re;
   logic          mem_we;

   // compute stage
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_start_ff;
   logic          s1_first_ff;
   logic [PW-1:0] s1_pos_ff;
   logic          s1_adv;

   // row state
   logic [7:0]    filter_kind_ff;
   logic          no_prior_ff;
   logic [7:0]    left_ff   [8];
   logic [7:0]    upleft_ff [8];

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_pixel_ff;
   logic [IW-1:0] rsp_index_ff;
   logic          rsp_ovf_ff;

   // compute results
   logic [3:0]    bpp_eff;
   logic [2:0]    nb_sel;
   logic          has_left;
   logic          s1_in_range;
   logic [7:0]    nb_a, nb_b, nb_c;
   logic [8:0]    ab_sum;
   logic [7:0]    recon;
   logic [IW-1:0] s1_index;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;

   always_comb begin
      bpp_in = bpp_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[2] == pngsu_pkg::REG_BYTES_PER_PIXEL) begin
         bpp_in = csr_pwdata[3:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == pngsu_pkg::REG_BYTES_PER_PIXEL) begin
         csr_prdata = {28'd0, bpp_ff};
      end
   end

   // ---------------- fetch ----------------
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_adv;
   assign req_accept   = req_tvalid && req_tready;
   assign req_start    = req_tuser[0];
   assign req_in_range = 32'(pos_ff) < MAX_ROW_BYTES;
   assign mem_re       = req_accept && !req_start && req_in_range;

   always_comb begin
      pos_in = pos_ff;
      if (req_accept) begin
         if (req_start) begin
            pos_in = '0;
         end else if (pos_ff != pngsu_pkg::POS_SAT) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // A row start always sits between the last write of one row and the first
   // read of the next, so a read never meets a pending write to its entry.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= line_mem[AW'(pos_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[AW'(s1_pos_ff)] <= recon;
      end
   end

   // ---------------- compute ----------------
   always_comb begin
      if (bpp_ff == 4'd0) begin
         bpp_eff = 4'd1;
      end else if (bpp_ff > pngsu_pkg::BPP_MAX) begin
         bpp_eff = pngsu_pkg::BPP_MAX;
      end else begin
         bpp_eff = bpp_ff;
      end
      nb_sel      = 3'(bpp_eff - 4'd1);
      has_left    = s1_pos_ff >= PW'(bpp_eff);
      s1_in_range = 32'(s1_pos_ff) < MAX_ROW_BYTES;

      nb_a = has_left ? left_ff[nb_sel] : 8'd0;
      nb_b = no_prior_ff ? 8'd0 : mem_rdata_ff;
      nb_c = (has_left && !no_prior_ff) ? upleft_ff[nb_sel] : 8'd0;
      ab_sum = {1'b0, nb_a} + {1'b0, nb_b};

      case (filter_kind_ff)
         pngsu_pkg::FILTER_SUB:   recon = s1_byte_ff + nb_a;
         pngsu_pkg::FILTER_UP:    recon = s1_byte_ff + nb_b;
         pngsu_pkg::FILTER_AVG:   recon = s1_byte_ff + ab_sum[8:1];
         pngsu_pkg::FILTER_PAETH: recon = s1_byte_ff + pngsu_pkg::paeth(nb_a, nb_b, nb_c);
         default:                 recon = s1_byte_ff;
      endcase

      s1_index = (s1_pos_ff > PW'(pngsu_pkg::IDX_SAT)) ? pngsu_pkg::IDX_SAT
                                                        : s1_pos_ff[IW-1:0];
   end

   assign mem_we = s1_adv && !s1_start_ff && s1_in_range;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && !s1_start_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and row state
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= pngsu_pkg::BPP_RESET;
         pos_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         filter_kind_ff <= pngsu_pkg::FILTER_NONE;
         no_prior_ff    <= 1'b1;
         for (int i = 0; i < 8; i++) begin
            left_ff[i]   <= 8'd0;
            upleft_ff[i] <= 8'd0;
         end
      end else begin
         bpp_ff       <= bpp_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            if (s1_start_ff) begin
               filter_kind_ff <= s1_byte_ff;
               no_prior_ff    <= s1_first_ff;
               for (int i = 0; i < 8; i++) begin
                  left_ff[i]   <= 8'd0;
                  upleft_ff[i] <= 8'd0;
               end
            end else if (s1_in_range) begin
               left_ff[0]   <= recon;
               upleft_ff[0] <= nb_b;
               for (int i = 1; i < 8; i++) begin
                  left_ff[i]   <= left_ff[i-1];
                  upleft_ff[i] <= upleft_ff[i-1];
               end
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_start;
         s1_first_ff <= req_tuser[1];
         s1_pos_ff   <= pos_ff;
      end
      if (s1_adv && !s1_start_ff) begin
         rsp_pixel_ff <= s1_in_range ? recon : s1_byte_ff;
         rsp_index_ff <= s1_index;
         rsp_ovf_ff   <= !s1_in_range;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_index_ff, rsp_pixel_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ rtl/core/pngsu_checker.sv @@
// Port-level checker for the PNG scanline unfilter and its bind to the top level.
// Depends on assert_macros.svh and on png_scanline_unfilter_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pngsu_checker #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_pready
);

   // lowest index a flagged byte can report, given saturation at 13 bits
   localparam int OVF_MIN_INDEX = (MAX_ROW_BYTES > 8191) ? 8191 : MAX_ROW_BYTES;

   `PNGSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `PNGSU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

   `PNGSU_ASSERT_IMPL(a_ovf_index, clock, reset, rsp_tvalid && rsp_tuser, 32'(rsp_tdata[20:8]) >= OVF_MIN_INDEX, "overflow flagged inside line storage")

   `PNGSU_ASSERT_IMPL(a_in_range_index, clock, reset, rsp_tvalid && !rsp_tuser, 32'(rsp_tdata[20:8]) < MAX_ROW_BYTES, "unflagged byte beyond line storage")

   `PNGSU_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready, "register port not ready")

endmodule

bind png_scanline_unfilter_unit pngsu_checker #(
   .MAX_ROW_BYTES(MAX_ROW_BYTES)
) u_pngsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

@@ tb/tb.sv @@
// Self-checking bench for png_scanline_unfilter_unit: random byte streams with
// row starts, bytes-per-pixel register sweeps, random flow control on both streams.
// Depends on pngsu_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;

   localparam int LINE_BYTES = 8192;
   localparam int QUIET_LIMIT = 3000;
   localparam logic [2:0] BPP_ADDR = {pngsu_pkg::REG_BYTES_PER_PIXEL, 2'b00};

   typedef struct packed {
      logic       first;
      logic       start;
      logic [7:0] data;
   } row_byte_type;

   typedef struct packed {
      logic        overflow;
      logic [12:0] index;
      logic [7:0]  pixel;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0]  req_tuser = 2'b00;   // [0] starts_row, [1] first_row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] pixel_byte, [20:8] byte_index
   logic        rsp_tuser;           // [0] overflow
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   png_scanline_unfilter_unit #(.MAX_ROW_BYTES(LINE_BYTES)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   row_byte_type     pending_bytes[$];
   pixel_result_type expected_pixels[$];
   int            mismatches = 0;
   int            quiet_cycles = 0;
   logic          idling_on = 1'b1;
   logic          long_hold_req = 1'b0;
   int            send_gap = 0;
   int            rsp_hold = 0;

   // predictor state
   logic [7:0]  line_mem [0:LINE_BYTES-1];
   logic [7:0]  left_hist [0:7];
   logic [7:0]  upleft_hist [0:7];
   logic [13:0] row_pos = '0;
   logic [7:0]  row_filter = pngsu_pkg::FILTER_NONE;
   logic        row_no_prior = 1'b1;
   logic [3:0]  bpp_reg = pngsu_pkg::BPP_RESET;

   // stimulus-side bookkeeping, so a row with a prior line never reads unwritten bytes
   int gen_pos = 0;
   int gen_line_len = 0;
   int gen_count = 0;

   initial begin
      for (int k = 0; k < 8; k++) begin
         left_hist[k] = 8'h00;
         upleft_hist[k] = 8'h00;
      end
   end

   function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
      int est;
      int da;
      int db;
      int dc;
      est = int'(a) + int'(b) - int'(c);
      da = est - int'(a);
      db = est - int'(b);
      dc = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   task automatic reconstruct_byte(input row_byte_type it);
      logic [3:0]    left_gap;
      logic [7:0]    a;
      logic [7:0]    b;
      logic [7:0]    c;
      logic [7:0]    r;
      pixel_result_type res;
      if (it.start) begin
         row_filter = it.data;
         row_no_prior = it.first;
         row_pos = '0;
         for (int k = 0; k < 8; k++) begin
            left_hist[k] = 8'h00;
            upleft_hist[k] = 8'h00;
         end
         return;
      end
      left_gap = (bpp_reg == 4'd0) ? 4'd1 :
                 (bpp_reg > pngsu_pkg::BPP_MAX) ? pngsu_pkg::BPP_MAX : bpp_reg;
      res.index = (row_pos > 14'd8191) ? pngsu_pkg::IDX_SAT : row_pos[12:0];
      if (row_pos >= LINE_BYTES) begin
         // past line storage: raw pass-through, neighbors untouched
         res.pixel = it.data;
         res.overflow = 1'b1;
         if (row_pos != pngsu_pkg::POS_SAT) row_pos++;
         expected_pixels.push_back(res);
         return;
      end
      a = 8'h00;
      b = 8'h00;
      c = 8'h00;
      if (row_pos >= left_gap) a = left_hist[left_gap-1];
      if (!row_no_prior) begin
         b = line_mem[row_pos];
         if (row_pos >= left_gap) c = upleft_hist[left_gap-1];
      end
      case (row_filter)
         pngsu_pkg::FILTER_SUB:   r = it.data + a;
         pngsu_pkg::FILTER_UP:    r = it.data + b;
         pngsu_pkg::FILTER_AVG:   r = it.data + 8'((9'(a) + 9'(b)) >> 1);
         pngsu_pkg::FILTER_PAETH: r = it.data + paeth_choice(a, b, c);
         default:                 r = it.data;
      endcase
      for (int k = 7; k > 0; k--) begin
         left_hist[k] = left_hist[k-1];
         upleft_hist[k] = upleft_hist[k-1];
      end
      left_hist[0] = r;
      upleft_hist[0] = b;
      line_mem[row_pos] = r;
      row_pos++;
      res.pixel = r;
      res.overflow = 1'b0;
      expected_pixels.push_back(res);
   endtask

   // request driver
   always @(posedge clock) begin
      logic         offer;
      row_byte_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) pending_bytes.delete(0);
         offer = 1'b0;
         if (req_tvalid && !req_tready) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (pending_bytes.size() != 0) begin
            if (idling_on && $urandom_range(0, 11) == 0) send_gap = $urandom_range(0, 8);
            else offer = 1'b1;
         end
         req_tvalid <= offer;
         if (offer) begin
            head = pending_bytes[0];
            req_tdata <= head.data;
            req_tuser <= {head.first, head.start};
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_hold = 80;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
         rsp_hold = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on request accept, then check any result
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) reconstruct_byte({req_tuser[1], req_tuser[0], req_tdata});
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: pixel_byte %0d byte_index %0d",
                      rsp_tdata[7:0], rsp_tdata[20:8]);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.pixel) begin
                  $error("pixel_byte: expected %0d, got %0d", want.pixel, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[20:8] !== want.index) begin
                  $error("byte_index: expected %0d, got %0d", want.index, rsp_tdata[20:8]);
                  mismatches++;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] d, input logic st, input logic fr);
      pending_bytes.push_back({fr, st, d});
      gen_count++;
      if (st) begin
         gen_pos = 0;
      end else begin
         if (gen_pos < LINE_BYTES && gen_pos + 1 > gen_line_len) gen_line_len = gen_pos + 1;
         gen_pos++;
      end
   endtask

   task automatic queue_row(input logic [7:0] kind, input logic first, input int len);
      if (gen_line_len == 0) first = 1'b1;
      if (!first && len > gen_line_len) len = gen_line_len;
      queue_byte(kind, 1'b1, first);
      repeat (len) queue_byte(pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic queue_random_rows(input int target);
      int         stop_at;
      int         len;
      logic [7:0] kind;
      logic       first;
      stop_at = gen_count + target;
      while (gen_count < stop_at) begin
         if ($urandom_range(0, 15) == 0) begin
            // stray row start, any type, no data behind it
            queue_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 9) == 0) kind = 8'($urandom_range(5, 255));
            else kind = 8'($urandom_range(0, 4));
            first = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0: len = 0;
               1: len = $urandom_range(41, 160);
               default: len = $urandom_range(1, 40);
            endcase
            queue_row(kind, first, len);
         end
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      // row starts give no result; let them clear the pipeline
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write_bpp(input logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= BPP_ADDR;
      csr_pwdata <= {28'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      bpp_reg = value;
   endtask

   task automatic csr_check_bpp();
      logic [31:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= BPP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== {28'd0, bpp_reg}) begin
         $error("bytes_per_pixel: expected %0d, got %0d", bpp_reg, got);
         mismatches++;
      end
   endtask

   initial begin
      logic [3:0] bpp_plan [0:8];
      bpp_plan = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd2, 4'd4, 4'd6, 4'd5};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_check_bpp();

      // bytes ahead of the first row start act as a None row with no prior line
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_row(pngsu_pkg::FILTER_NONE, 1'b1, 4);
      queue_row(pngsu_pkg::FILTER_SUB, 1'b0, 3);
      queue_row(pngsu_pkg::FILTER_UP, 1'b0, 3);
      queue_row(pngsu_pkg::FILTER_AVG, 1'b0, 3);
      queue_row(pngsu_pkg::FILTER_PAETH, 1'b0, 3);
      queue_row(8'hFF, 1'b0, 2);
      wait_drained();

      for (int i = 0; i < 9; i++) begin
         csr_write_bpp(bpp_plan[i]);
         csr_check_bpp();
         if (i == 8) idling_on = 1'b0;
         if (i == 2) long_hold_req = 1'b1;
         queue_random_rows(65);
         wait_drained();
      end

      if (expected_pixels.size() != 0) begin
         $error("%0d results never arrived", expected_pixels.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
